// ===== rtl/core/fsmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package fsmc_pkg;

  localparam int unsigned KindW = 4;
  localparam int unsigned WordW = 32;
  localparam int unsigned ClassW = 10;

  typedef enum logic [KindW-1:0] {
    KIND_SGNJ  = 4'd0,
    KIND_SGNJN = 4'd1,
    KIND_SGNJX = 4'd2,
    KIND_MIN   = 4'd3,
    KIND_MAX   = 4'd4,
    KIND_EQ    = 4'd5,
    KIND_LT    = 4'd6,
    KIND_LE    = 4'd7,
    KIND_CLASS = 4'd8
  } kind_e;

  localparam logic [WordW-1:0] CanonNan = 32'h7FC0_0000;

  // per-operand decode
  typedef struct packed {
    logic              is_nan;
    logic              is_snan;
    logic              mag_zero;
    logic [ClassW-1:0] cls;
    logic [WordW-1:0]  key;
  } opinfo_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
  } item_t;

  typedef struct packed {
    logic [WordW-1:0] value;
    logic             invalid;
  } res_t;

  function automatic opinfo_t decode(input logic [WordW-1:0] v);
    opinfo_t o;
    logic    exp_ones;
    logic    exp_zero;
    logic    frac_zero;
    exp_ones  = &v[30:23];
    exp_zero  = ~|v[30:23];
    frac_zero = ~|v[22:0];
    o.is_nan   = exp_ones & ~frac_zero;
    o.is_snan  = exp_ones & ~frac_zero & ~v[22];
    o.mag_zero = exp_zero & frac_zero;
    o.key      = v[31] ? ~v : {1'b1, v[30:0]};
    o.cls      = '0;
    if (exp_ones) begin
      if (frac_zero) o.cls[v[31] ? 0 : 7] = 1'b1;
      else o.cls[v[22] ? 9 : 8] = 1'b1;
    end else if (exp_zero) begin
      if (frac_zero) o.cls[v[31] ? 3 : 4] = 1'b1;
      else o.cls[v[31] ? 2 : 5] = 1'b1;
    end else begin
      o.cls[v[31] ? 1 : 6] = 1'b1;
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/fsmc_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// one elastic register stage with valid, full-rate while out_ready_i is high
module fsmc_stage #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [Width-1:0] in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [Width-1:0]      out_data_o
);
  logic             valid_q;
  logic [Width-1:0] data_q;

  assign in_ready_o  = ~valid_q | out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_ready_i |=> valid_q && $stable(data_q))
    else $error("stage lost word under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q |-> in_ready_o)
    else $error("empty stage not ready");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> valid_q)
    else $error("accepted word not held");
endmodule
`default_nettype wire

// ===== rtl/core/fp32_sign_minmax_compare_classify_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// RISC-V F sign-inject / min / max / compare / classify unit. Three register
// stages (input, operand decode, result select); each word passes through the
// input, decode and result registers in that order before m_axis_tvalid rises.
// One word is taken every cycle while m_axis_tready stays high.
// Each stage holds when the one after it is full and stalled.
module fp32_sign_minmax_compare_classify_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // [3:0] kind, [35:4] operand_a, [67:36] operand_b
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata   // [31:0] result_value, [32] invalid_flag
);
  localparam int unsigned ItemW = $bits(fsmc_pkg::item_t);
  localparam int unsigned DecW  = ItemW + 2 * $bits(fsmc_pkg::opinfo_t);
  localparam int unsigned ResW  = $bits(fsmc_pkg::res_t);

  typedef struct packed {
    fsmc_pkg::item_t   it;
    fsmc_pkg::opinfo_t da;
    fsmc_pkg::opinfo_t db;
  } dec_t;

  fsmc_pkg::item_t s0_in, s1_item;
  dec_t            s1_dec, s2_dec;
  fsmc_pkg::res_t  s2_res, s3_res;
  logic v1, r1, v2, r2;

  always_comb begin
    s0_in.kind = s_axis_tdata[3:0];
    s0_in.a    = s_axis_tdata[35:4];
    s0_in.b    = s_axis_tdata[67:36];
  end

  fsmc_stage #(.Width(ItemW)) u_st1 (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_data_i(s0_in),
    .out_valid_o(v1), .out_ready_i(r1), .out_data_o(s1_item)
  );

  always_comb begin
    s1_dec.it = s1_item;
    s1_dec.da = fsmc_pkg::decode(s1_item.a);
    s1_dec.db = fsmc_pkg::decode(s1_item.b);
  end

  fsmc_stage #(.Width(DecW)) u_st2 (
    .clk_i, .rst_ni,
    .in_valid_i(v1), .in_ready_o(r1), .in_data_i(s1_dec),
    .out_valid_o(v2), .out_ready_i(r2), .out_data_o(s2_dec)
  );

  logic any_nan, any_snan, bz, eq, lt, a_le_b, a_ge_b;
  always_comb begin
    any_nan  = s2_dec.da.is_nan | s2_dec.db.is_nan;
    any_snan = s2_dec.da.is_snan | s2_dec.db.is_snan;
    bz       = s2_dec.da.mag_zero & s2_dec.db.mag_zero;
    eq       = ~any_nan & ((s2_dec.it.a == s2_dec.it.b) | bz);
    lt       = ~any_nan & ~bz & (s2_dec.da.key < s2_dec.db.key);
    a_le_b   = s2_dec.da.key <= s2_dec.db.key;
    a_ge_b   = s2_dec.da.key >= s2_dec.db.key;
    s2_res   = '0;
    case (s2_dec.it.kind)
      fsmc_pkg::KIND_SGNJ:  s2_res.value = {s2_dec.it.b[31], s2_dec.it.a[30:0]};
      fsmc_pkg::KIND_SGNJN: s2_res.value = {~s2_dec.it.b[31], s2_dec.it.a[30:0]};
      fsmc_pkg::KIND_SGNJX: s2_res.value = {s2_dec.it.a[31] ^ s2_dec.it.b[31],
                                            s2_dec.it.a[30:0]};
      fsmc_pkg::KIND_MIN, fsmc_pkg::KIND_MAX: begin
        if (s2_dec.da.is_nan && s2_dec.db.is_nan) s2_res.value = fsmc_pkg::CanonNan;
        else if (s2_dec.da.is_nan) s2_res.value = s2_dec.it.b;
        else if (s2_dec.db.is_nan) s2_res.value = s2_dec.it.a;
        else if (s2_dec.it.kind == fsmc_pkg::KIND_MAX)
          s2_res.value = a_ge_b ? s2_dec.it.a : s2_dec.it.b;
        else s2_res.value = a_le_b ? s2_dec.it.a : s2_dec.it.b;
        s2_res.invalid = any_snan;
      end
      fsmc_pkg::KIND_EQ: begin
        s2_res.value   = {31'd0, eq};
        s2_res.invalid = any_snan;
      end
      fsmc_pkg::KIND_LT: begin
        s2_res.value   = {31'd0, lt};
        s2_res.invalid = any_nan;
      end
      fsmc_pkg::KIND_LE: begin
        s2_res.value   = {31'd0, lt | eq};
        s2_res.invalid = any_nan;
      end
      fsmc_pkg::KIND_CLASS: s2_res.value = {22'd0, s2_dec.da.cls};
      default: s2_res = '0;
    endcase
  end

  fsmc_stage #(.Width(ResW)) u_st3 (
    .clk_i, .rst_ni,
    .in_valid_i(v2), .in_ready_o(r2), .in_data_i(s2_res),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(s3_res)
  );

  assign m_axis_tdata = {7'd0, s3_res.invalid, s3_res.value};
endmodule
`default_nettype wire
